@@ rtl/html_source_minifier_core_defines.svh @@
// Assertion macros shared by the minifier checker.
// No dependencies; include once per compilation unit.
`ifndef HTML_SOURCE_MINIFIER_CORE_DEFINES_SVH
`define HTML_SOURCE_MINIFIER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clk.
`define HSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("minifier check failed");

// Next-cycle implication, sampled on the rising edge of clk.
`define HSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("minifier check failed");

`endif

@@ rtl/hsm_pkg.sv @@
// Types, constants and character helpers for the HTML source minifier.
// No dependencies.
`timescale 1ns / 1ps
package hsm_pkg;

    typedef enum logic [5:0] {
        MODE_TEXT    = 6'b000001,
        MODE_HELD    = 6'b000010,
        MODE_NAME    = 6'b000100,
        MODE_BODY    = 6'b001000,
        MODE_COMMENT = 6'b010000,
        MODE_DOCTYPE = 6'b100000
    } mode_t;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } quote_t;

    typedef enum logic [2:0] {
        RAW_NONE     = 3'd0,
        RAW_PRE      = 3'd1,
        RAW_TEXTAREA = 3'd2,
        RAW_SCRIPT   = 3'd3,
        RAW_STYLE    = 3'd4
    } raw_t;

    typedef enum logic [1:0] {
        REG_OMIT_DOCTYPE = 2'd0,
        REG_COLLAPSE_WS  = 2'd1,
        REG_PRESERVE_CMT = 2'd2
    } reg_idx_t;

    localparam int HELD_DEPTH = 8;
    localparam logic [3:0] COMMENT_LEN = 4'd4;
    localparam logic [3:0] DOCTYPE_LEN = 4'd9;
    localparam logic [3:0] NAME_MAX    = 4'd15;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D)
            || (c == 8'h0C);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [7:0] comment_char(input logic [3:0] p);
        case (p)
            4'd0:    comment_char = "<";
            4'd1:    comment_char = "!";
            4'd2:    comment_char = "-";
            4'd3:    comment_char = "-";
            default: comment_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] doctype_char(input logic [3:0] p);
        case (p)
            4'd0:    doctype_char = "<";
            4'd1:    doctype_char = "!";
            4'd2:    doctype_char = "d";
            4'd3:    doctype_char = "o";
            4'd4:    doctype_char = "c";
            4'd5:    doctype_char = "t";
            4'd6:    doctype_char = "y";
            4'd7:    doctype_char = "p";
            4'd8:    doctype_char = "e";
            default: doctype_char = 8'h00;
        endcase
    endfunction

    function automatic logic [3:0] raw_len(input logic [1:0] k);
        case (k)
            2'd0:    raw_len = 4'd3;
            2'd1:    raw_len = 4'd8;
            2'd2:    raw_len = 4'd6;
            default: raw_len = 4'd5;
        endcase
    endfunction

    // Character p of raw element name k; zero past the end of the name.
    function automatic logic [7:0] raw_char(input logic [1:0] k, input logic [3:0] p);
        logic [63:0] s;
        case (k)
            2'd0:    s = {"pre", 40'd0};
            2'd1:    s = "textarea";
            2'd2:    s = {"script", 16'd0};
            default: s = {"style", 24'd0};
        endcase
        if (p >= raw_len(k))
            raw_char = 8'h00;
        else
            raw_char = s[63 - 8 * p[2:0] -: 8];
    endfunction

endpackage

@@ rtl/html_source_minifier_core.sv @@
// Top level of the HTML source minifier: parser state, held prefix and result sequencer.
// Depends on hsm_pkg.
`timescale 1ns / 1ps

// Streaming HTML minifier. Each accepted byte is parsed in the cycle it is
// taken and its results (up to nine bytes, or one marker at a source end)
// are placed in a result register that presents one result per cycle while
// out_stall is low. A byte that causes at most one result is taken every
// cycle while out_stall is low; a byte that replays a held prefix holds the
// result register until its last result is taken, and in_stall stays high
// until then. The replay length is set by the eight-entry held-prefix store.
module html_source_minifier_core
    import hsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       source_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       source_end
);

    logic omit_doctype_reg, collapse_ws_reg, preserve_cmt_reg;

    mode_t      mode_reg, mode_next;
    logic [7:0] held_reg [HELD_DEPTH];
    logic [7:0] held_next [HELD_DEPTH];
    logic [3:0] held_cnt_reg, held_cnt_next;
    logic [1:0] dash_reg, dash_next;
    quote_t     quote_reg, quote_next;
    logic [3:0] name_len_reg, name_len_next;
    logic [3:0] cand_reg, cand_next;
    logic       closing_reg, closing_next;
    raw_t       raw_reg, raw_next;
    logic       prior_reg, prior_next;

    logic [3:0] rep_cnt;
    logic       emit_en;
    logic [7:0] emit_val;

    logic       job_valid_reg;
    logic [3:0] job_rep_reg;
    logic [7:0] job_held_reg [HELD_DEPTH];
    logic       job_has_reg;
    logic [7:0] job_byte_reg;
    logic       job_last_reg;
    logic [3:0] idx_reg;
    logic [3:0] job_total;
    logic [3:0] last_idx;
    logic       cur_last;
    logic       in_acc;
    logic       out_acc;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            omit_doctype_reg <= 1'b0;
            collapse_ws_reg  <= 1'b1;
            preserve_cmt_reg <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_OMIT_DOCTYPE: omit_doctype_reg <= cfg_data;
                REG_COLLAPSE_WS:  collapse_ws_reg  <= cfg_data;
                REG_PRESERVE_CMT: preserve_cmt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Parse step for one byte.
    always_comb begin
        logic [7:0] c;
        logic [7:0] lc;
        logic       cm_ok, dt_ok;
        logic       done;
        logic [1:0] match;
        mode_t      m;

        c  = in_byte;
        lc = to_lower(in_byte);
        for (int i = 0; i < HELD_DEPTH; i++) held_next[i] = held_reg[i];
        held_cnt_next = held_cnt_reg;
        dash_next     = dash_reg;
        quote_next    = quote_reg;
        name_len_next = name_len_reg;
        cand_next     = cand_reg;
        closing_next  = closing_reg;
        raw_next      = raw_reg;
        prior_next    = prior_reg;
        mode_next     = mode_reg;
        rep_cnt       = 4'd0;
        emit_en       = 1'b0;
        emit_val      = c;
        done          = 1'b0;
        match         = 2'd0;
        m             = mode_reg;

        // Prefix compare of the held bytes and this byte against both openers.
        cm_ok = (held_cnt_reg < COMMENT_LEN) && (lc == comment_char(held_cnt_reg));
        dt_ok = (held_cnt_reg < DOCTYPE_LEN) && (lc == doctype_char(held_cnt_reg));
        for (int i = 0; i < HELD_DEPTH; i++) begin
            if (4'(i) < held_cnt_reg) begin
                if (to_lower(held_reg[i]) != comment_char(4'(i))) cm_ok = 1'b0;
                if (to_lower(held_reg[i]) != doctype_char(4'(i))) dt_ok = 1'b0;
            end
        end

        if (m == MODE_HELD) begin
            if (cm_ok) begin
                done = 1'b1;
                if (held_cnt_reg == COMMENT_LEN - 4'd1) begin
                    if (preserve_cmt_reg) begin
                        rep_cnt    = held_cnt_reg;
                        emit_en    = 1'b1;
                        prior_next = 1'b0;
                    end
                    held_cnt_next = 4'd0;
                    dash_next     = 2'd0;
                    mode_next     = MODE_COMMENT;
                end else begin
                    held_next[held_cnt_reg[2:0]] = c;
                    held_cnt_next = held_cnt_reg + 4'd1;
                end
            end else if (omit_doctype_reg && dt_ok) begin
                done = 1'b1;
                if (held_cnt_reg == DOCTYPE_LEN - 4'd1) begin
                    held_cnt_next = 4'd0;
                    mode_next     = MODE_DOCTYPE;
                end else begin
                    held_next[held_cnt_reg[2:0]] = c;
                    held_cnt_next = held_cnt_reg + 4'd1;
                end
            end else begin
                // Prefix failed: replay it as tag bytes and treat c as part of the tag.
                rep_cnt       = held_cnt_reg;
                quote_next    = QUOTE_NONE;
                name_len_next = 4'd0;
                cand_next     = 4'hF;
                closing_next  = 1'b0;
                m             = (held_cnt_reg >= 4'd2) ? MODE_BODY : MODE_NAME;
                held_cnt_next = 4'd0;
            end
        end

        if (!done && (m == MODE_NAME || m == MODE_BODY)) begin
            prior_next = 1'b0;
            emit_en    = 1'b1;
            mode_next  = m;
            if (m == MODE_NAME) begin
                if (c == "/" && name_len_next == 4'd0 && !closing_next) begin
                    closing_next = 1'b1;
                    done = 1'b1;
                end else if (is_letter(c)) begin
                    for (int k = 0; k < 4; k++) begin
                        if (name_len_next >= raw_len(2'(k))
                                || lc != raw_char(2'(k), name_len_next))
                            cand_next[k] = 1'b0;
                    end
                    if (name_len_next < NAME_MAX) name_len_next = name_len_next + 4'd1;
                    done = 1'b1;
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        if (cand_next[k] && name_len_next == raw_len(2'(k)))
                            match = 2'(k);
                    end
                    if (cand_next != 4'd0 && (|(cand_next & {
                            name_len_next == raw_len(2'd3), name_len_next == raw_len(2'd2),
                            name_len_next == raw_len(2'd1), name_len_next == raw_len(2'd0)})))
                    begin
                        if (!closing_next)
                            raw_next = raw_t'({1'b0, match} + 3'd1);
                        else if (raw_next == raw_t'({1'b0, match} + 3'd1))
                            raw_next = RAW_NONE;
                    end
                    mode_next = MODE_BODY;
                end
            end
            if (!done) begin
                if (quote_next != QUOTE_NONE) begin
                    if ((quote_next == QUOTE_SINGLE && c == "'")
                            || (quote_next == QUOTE_DOUBLE && c == "\""))
                        quote_next = QUOTE_NONE;
                end else if (c == "'") begin
                    quote_next = QUOTE_SINGLE;
                end else if (c == "\"") begin
                    quote_next = QUOTE_DOUBLE;
                end else if (c == ">") begin
                    mode_next = MODE_TEXT;
                end
            end
        end else if (!done && m == MODE_COMMENT) begin
            if (preserve_cmt_reg) begin
                emit_en    = 1'b1;
                prior_next = 1'b0;
            end
            if (c == ">" && dash_reg == 2'd2)
                mode_next = MODE_TEXT;
            else if (c == "-")
                dash_next = (dash_reg == 2'd2) ? 2'd2 : dash_reg + 2'd1;
            else
                dash_next = 2'd0;
        end else if (!done && m == MODE_DOCTYPE) begin
            if (c == ">") mode_next = MODE_TEXT;
        end else if (!done && m == MODE_TEXT) begin
            if (c == "<") begin
                held_next[0]  = c;
                held_cnt_next = 4'd1;
                mode_next     = MODE_HELD;
            end else if (collapse_ws_reg && raw_reg == RAW_NONE && is_space(c)) begin
                emit_en    = !prior_reg;
                emit_val   = " ";
                prior_next = 1'b1;
            end else begin
                emit_en    = 1'b1;
                prior_next = 1'b0;
            end
        end

        // A source end flushes any held prefix and resets everything but prior_next.
        if (source_last) begin
            if (mode_next == MODE_HELD) begin
                rep_cnt    = held_cnt_next;
                prior_next = 1'b0;
            end
            mode_next     = MODE_TEXT;
            held_cnt_next = 4'd0;
            dash_next     = 2'd0;
            quote_next    = QUOTE_NONE;
            name_len_next = 4'd0;
            cand_next     = 4'hF;
            closing_next  = 1'b0;
            raw_next      = RAW_NONE;
        end
    end

    assign job_total = job_rep_reg + {3'd0, job_has_reg};
    assign last_idx  = (job_total == 4'd0) ? 4'd0 : job_total - 4'd1;
    assign cur_last  = (idx_reg == last_idx);
    assign out_acc   = job_valid_reg && !out_stall;
    assign in_stall  = job_valid_reg && !(!out_stall && cur_last);
    assign in_acc    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg      <= MODE_TEXT;
            held_cnt_reg  <= 4'd0;
            dash_reg      <= 2'd0;
            quote_reg     <= QUOTE_NONE;
            name_len_reg  <= 4'd0;
            cand_reg      <= 4'hF;
            closing_reg   <= 1'b0;
            raw_reg       <= RAW_NONE;
            prior_reg     <= 1'b0;
            job_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end else begin
            if (in_acc) begin
                mode_reg     <= mode_next;
                held_cnt_reg <= held_cnt_next;
                dash_reg     <= dash_next;
                quote_reg    <= quote_next;
                name_len_reg <= name_len_next;
                cand_reg     <= cand_next;
                closing_reg  <= closing_next;
                raw_reg      <= raw_next;
                prior_reg    <= prior_next;
            end
            if (in_acc && (rep_cnt != 4'd0 || emit_en || source_last)) begin
                job_valid_reg <= 1'b1;
                idx_reg       <= 4'd0;
            end else if (out_acc && cur_last) begin
                job_valid_reg <= 1'b0;
            end else if (out_acc) begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_acc) begin
            for (int i = 0; i < HELD_DEPTH; i++) begin
                held_reg[i]     <= held_next[i];
                job_held_reg[i] <= held_next[i];
            end
            job_rep_reg  <= rep_cnt;
            job_has_reg  <= emit_en;
            job_byte_reg <= emit_val;
            job_last_reg <= source_last;
        end
    end

    always_comb begin
        out_valid  = job_valid_reg;
        run_last   = cur_last;
        source_end = cur_last && job_last_reg;
        if (idx_reg < job_rep_reg) begin
            out_byte   = job_held_reg[idx_reg[2:0]];
            byte_valid = 1'b1;
        end else if (job_has_reg) begin
            out_byte   = job_byte_reg;
            byte_valid = 1'b1;
        end else begin
            out_byte   = 8'h00;
            byte_valid = 1'b0;
        end
    end

endmodule

@@ rtl/hsm_checker.sv @@
// Port-level checks for the HTML source minifier, bound to the top level.
// Depends on html_source_minifier_core_defines.svh.
`timescale 1ns / 1ps
`include "html_source_minifier_core_defines.svh"

module hsm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       run_last,
    input logic       source_end
);

    // A marker transaction only closes a source.
    `HSM_ASSERT_NOW(a_marker_ends_source, out_valid && !byte_valid, source_end && run_last)
    `HSM_ASSERT_NOW(a_marker_zero, out_valid && !byte_valid, out_byte == 8'h00)
    `HSM_ASSERT_NOW(a_end_is_last, out_valid && source_end, run_last)
    `HSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte))
    // A stalled result blocks any new input transaction.
    `HSM_ASSERT_NOW(a_in_blocked, in_valid && out_valid && out_stall, in_stall)

endmodule

bind html_source_minifier_core hsm_checker u_hsm_checker (.*);

@@ sim/tb_html_source_minifier_core.sv @@
// Self-checking testbench for the HTML source minifier core.
// Depends on hsm_pkg and html_source_minifier_core; predicts every result byte and marker.
`timescale 1ns / 1ps

module tb_html_source_minifier_core
    import hsm_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int MODE_TXT = 0;
    localparam int MODE_HLD = 1;
    localparam int MODE_NM = 2;
    localparam int MODE_BD = 3;
    localparam int MODE_CMT = 4;
    localparam int MODE_DT = 5;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } src_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       bvalid;
        logic       rlast;
        logic       send;
    } min_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic       cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       source_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       source_end;

    html_source_minifier_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
        .source_last(source_last), .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .byte_valid(byte_valid), .run_last(run_last),
        .source_end(source_end)
    );

    src_item_t   pending_bytes[$];
    min_result_t expected_out[$];
    int          mismatches;
    int          cycles;
    int          results_seen;
    int          bytes_sent;
    int          burst_left;
    int          gap_left;
    int          stall_phase;

    // Predictor state and its copy of the configuration.
    logic       p_omit;
    logic       p_collapse;
    logic       p_keep_cmt;
    int         p_mode;
    logic [7:0] p_held[8];
    int         p_held_n;
    int         p_dashes;
    quote_t     p_quote;
    int         p_name_len;
    logic [3:0] p_cands;
    logic       p_closing;
    raw_t       p_raw;
    logic       p_space;
    min_result_t step_out[$];

    string raw_names[4] = '{"pre", "textarea", "script", "style"};

    function automatic logic [7:0] lc(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic ws(logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0C;
    endfunction

    task automatic push_byte(logic [7:0] c);
        min_result_t r;
        if (step_out.size() >= 10)
            return;
        r = '{data: c, bvalid: 1'b1, rlast: 1'b0, send: 1'b0};
        step_out.push_back(r);
    endtask

    task automatic reset_tag();
        p_quote = QUOTE_NONE;
        p_name_len = 0;
        p_cands = 4'hF;
        p_closing = 1'b0;
    endtask

    task automatic tag_char(logic [7:0] c);
        int match;
        p_space = 1'b0;
        if (p_mode == MODE_NM) begin
            if (c == "/" && p_name_len == 0 && !p_closing) begin
                p_closing = 1'b1;
                push_byte(c);
                return;
            end
            if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
                for (int k = 0; k < 4; k++)
                    if (p_name_len >= raw_names[k].len() || lc(c) != raw_names[k][p_name_len])
                        p_cands[k] = 1'b0;
                if (p_name_len < 15)
                    p_name_len++;
                push_byte(c);
                return;
            end
            match = 0;
            for (int k = 0; k < 4; k++)
                if (p_cands[k] && p_name_len == raw_names[k].len())
                    match = k + 1;
            if (!p_closing && match != 0)
                p_raw = raw_t'(match);
            else if (p_closing && p_raw != RAW_NONE && match == int'(p_raw))
                p_raw = RAW_NONE;
            p_mode = MODE_BD;
        end
        push_byte(c);
        if (p_quote != QUOTE_NONE) begin
            if ((p_quote == QUOTE_SINGLE && c == "'") || (p_quote == QUOTE_DOUBLE && c == "\""))
                p_quote = QUOTE_NONE;
        end else if (c == "'")
            p_quote = QUOTE_SINGLE;
        else if (c == "\"")
            p_quote = QUOTE_DOUBLE;
        else if (c == ">")
            p_mode = MODE_TXT;
    endtask

    function automatic logic prefix_fits(string pat, logic [7:0] c);
        if (p_held_n + 1 > pat.len())
            return 1'b0;
        for (int i = 0; i < p_held_n; i++)
            if (lc(p_held[i]) != pat[i])
                return 1'b0;
        return lc(c) == pat[p_held_n];
    endfunction

    task automatic replay();
        for (int i = 0; i < p_held_n && i < 8; i++)
            push_byte(p_held[i]);
        p_space = 1'b0;
    endtask

    task automatic predict_byte(src_item_t it);
        logic [7:0] c;
        min_result_t r;
        c = it.data;
        step_out.delete();
        case (p_mode)
            MODE_HLD: begin
                if (prefix_fits("<!--", c)) begin
                    if (p_held_n + 1 == 4) begin
                        if (p_keep_cmt) begin
                            replay();
                            push_byte(c);
                        end
                        p_held_n = 0;
                        p_dashes = 0;
                        p_mode = MODE_CMT;
                    end else begin
                        p_held[p_held_n] = c;
                        p_held_n++;
                    end
                end else if (p_omit && prefix_fits("<!doctype", c)) begin
                    if (p_held_n + 1 == 9) begin
                        p_held_n = 0;
                        p_mode = MODE_DT;
                    end else begin
                        p_held[p_held_n] = c;
                        p_held_n++;
                    end
                end else begin
                    replay();
                    reset_tag();
                    p_mode = p_held_n >= 2 ? MODE_BD : MODE_NM;
                    p_held_n = 0;
                    tag_char(c);
                end
            end
            MODE_NM, MODE_BD: tag_char(c);
            MODE_CMT: begin
                if (p_keep_cmt) begin
                    push_byte(c);
                    p_space = 1'b0;
                end
                if (c == ">" && p_dashes >= 2)
                    p_mode = MODE_TXT;
                else if (c == "-")
                    p_dashes = p_dashes < 2 ? p_dashes + 1 : 2;
                else
                    p_dashes = 0;
            end
            MODE_DT: if (c == ">") p_mode = MODE_TXT;
            default: begin
                if (c == "<") begin
                    p_held[0] = c;
                    p_held_n = 1;
                    p_mode = MODE_HLD;
                end else if (p_collapse && p_raw == RAW_NONE && ws(c)) begin
                    if (!p_space)
                        push_byte(" ");
                    p_space = 1'b1;
                end else begin
                    push_byte(c);
                    p_space = 1'b0;
                end
            end
        endcase
        if (it.last) begin
            if (p_mode == MODE_HLD)
                replay();
            p_mode = MODE_TXT;
            p_held_n = 0;
            p_dashes = 0;
            reset_tag();
            p_raw = RAW_NONE;
            if (step_out.size() == 0) begin
                r = '0;
                step_out.push_back(r);
            end
            step_out[step_out.size() - 1].send = 1'b1;
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].rlast = 1'b1;
        foreach (step_out[i])
            expected_out.push_back(step_out[i]);
    endtask

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Driver: bursts of transactions separated by random gaps.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_byte <= 8'd0;
            source_last <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_byte(pending_bytes.pop_front());
                bytes_sent++;
            end
            if (in_valid && in_stall) begin
                // Hold the stalled payload.
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                in_valid <= 1'b1;
                in_byte <= pending_bytes[0].data;
                source_last <= pending_bytes[0].last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                end else
                    burst_left <= burst_left - 1;
            end else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall pattern and result monitor.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if ((stall_phase / 64) % 3 == 0)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 2) == 0);
            if (out_valid && !out_stall) begin
                min_result_t got;
                min_result_t want;
                got = '{data: out_byte, bvalid: byte_valid, rlast: run_last, send: source_end};
                results_seen++;
                if (expected_out.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h (nothing pending)", got);
                end else begin
                    want = expected_out.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected byte %h bv %b rl %b se %b, got %h %b %b %b",
                                want.data, want.bvalid, want.rlast, want.send,
                                got.data, got.bvalid, got.rlast, got.send);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic add_text(string s, logic end_src);
        src_item_t it;
        for (int i = 0; i < s.len(); i++) begin
            it.data = s[i];
            it.last = end_src && (i == s.len() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    task automatic set_reg(reg_idx_t idx, logic val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_OMIT_DOCTYPE: p_omit = val;
            REG_COLLAPSE_WS:  p_collapse = val;
            default:          p_keep_cmt = val;
        endcase
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || in_valid || expected_out.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // One short source: a fragment or a random byte, then a random closing byte.
    task automatic random_source();
        string frags[16] = '{"<!--", "-->", "<!DOCTYPE html>", "<pre>", "</pre>",
            "<textarea>", "</textarea>", "<SCRIPT>", "</script>", "<style a='>'>",
            "</style>", "  \t\n ", "<div class=\"x>y\">", "</div>", "<!-", "<!doc"};
        src_item_t it;
        if ($urandom_range(0, 3) == 0) begin
            it.data = 8'($urandom());
            it.last = 1'b0;
            pending_bytes.push_back(it);
        end else
            add_text(frags[$urandom_range(0, 15)], 1'b0);
        it.data = 8'($urandom());
        it.last = 1'b1;
        pending_bytes.push_back(it);
    endtask

    initial begin
        src_item_t it;
        mismatches = 0;
        cycles = 0;
        results_seen = 0;
        bytes_sent = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_OMIT_DOCTYPE;
        cfg_data = 1'b0;
        p_omit = 1'b0;
        p_collapse = 1'b1;
        p_keep_cmt = 1'b0;
        p_mode = MODE_TXT;
        p_held_n = 0;
        p_dashes = 0;
        reset_tag();
        p_raw = RAW_NONE;
        p_space = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: comments, held prefix replay, raw tags, byte extremes.
        add_text("a  <!-- x --> <b>", 1'b0);
        add_text("<pre>  </PRE> <!x>", 1'b1);
        it = '{data: 8'hFF, last: 1'b0};
        pending_bytes.push_back(it);
        it = '{data: 8'h00, last: 1'b1};
        pending_bytes.push_back(it);
        drain();
        set_reg(REG_OMIT_DOCTYPE, 1'b1);
        set_reg(REG_PRESERVE_CMT, 1'b1);
        set_reg(REG_COLLAPSE_WS, 1'b0);
        add_text("<!DocType x>  <!-- k -->", 1'b0);
        add_text("<abcdefghijklmnopq>", 1'b1);
        add_text("<!doctyp", 1'b1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            set_reg(REG_OMIT_DOCTYPE, phase[0]);
            set_reg(REG_COLLAPSE_WS, phase[1]);
            set_reg(REG_PRESERVE_CMT, phase[2]);
            random_source();
            drain();
        end

        $display("Sent %0d source bytes and checked %0d results over all register settings.",
            bytes_sent, results_seen);
        if (mismatches == 0 && expected_out.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
